// ----- hdl/ursb_pkg.sv -----
// types and codes shared by the udp receive slot buffer modules
// no dependencies
package ursb_pkg;

  localparam int unsigned LENGTH_W  = 10;
  localparam int unsigned HDR_BYTES = 8;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_POLL    = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_BYTE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_SHORT_HDR = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_NO_SLOT   = 3'd4
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] poll_port;
    logic [15:0] capacity;
  } in_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [2:0]          status;
    logic                found;
    logic [LENGTH_W-1:0] length;
    logic [7:0]          out_byte;
    logic                out_last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic load_imm;
    logic load_rd;
  } cmd_t;

  typedef struct packed {
    logic imm_result;
    logic read_hit;
  } sts_t;

endpackage

// ----- hdl/ursb_ctrl.sv -----
// handshake controller: input acceptance, memory read wait and output valid
// depends on ursb_pkg
module ursb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ursb_pkg::sts_t sts_i,
  output ursb_pkg::cmd_t cmd_o
);
  import ursb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      CS_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          cmd_o.accept = 1'b1;
          if (sts_i.read_hit) begin
            state_d = CS_READ;
          end else if (sts_i.imm_result) begin
            cmd_o.load_imm = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      CS_READ: begin
        if (out_free) begin
          cmd_o.load_rd = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  a_read_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_READ |-> in_stall_o)
    else $error("input not stalled during memory read");

  a_read_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_READ |-> !out_valid_q)
    else $error("output register busy during memory read");

  a_read_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && sts_i.read_hit |=> state_q == CS_READ && !out_valid_q)
    else $error("read transfer did not start a memory read");

endmodule

// ----- hdl/ursb_datapath.sv -----
// slot table, payload memory, header parsing and output register
// depends on ursb_pkg
module ursb_datapath #(
  parameter int unsigned SLOT_COUNT  = 2,
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ursb_pkg::in_t  in_i,
  input  ursb_pkg::cmd_t cmd_i,
  output ursb_pkg::sts_t sts_o,
  output ursb_pkg::out_t out_o
);
  import ursb_pkg::*;

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_PAYLOAD);
  localparam int unsigned DEPTH  = SLOT_COUNT * MAX_PAYLOAD;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [SLOT_COUNT-1:0] slot_valid_q, slot_valid_d;
  logic [15:0]           slot_port_q [SLOT_COUNT];
  logic [LEN_W-1:0]      slot_len_q  [SLOT_COUNT];
  logic [7:0]            mem [DEPTH];
  logic [7:0]            rd_data_q;
  logic                  rd_last_q;

  logic [15:0]       bytes_seen_q, bytes_seen_d;
  logic [15:0]       hdr_port_q, hdr_port_d;
  logic [15:0]       hdr_len_q, hdr_len_d;
  logic [SLOT_W-1:0] fill_slot_q, fill_slot_d;
  logic              fill_poss_q, fill_poss_d;
  logic [SLOT_W-1:0] read_slot_q, read_slot_d;
  logic [IDX_W-1:0]  read_idx_q, read_idx_d;
  logic [LEN_W-1:0]  read_rem_q, read_rem_d;
  out_t              out_q;
  out_t              imm_out;
  out_t              rd_out;

  logic              free_any;
  logic [SLOT_W-1:0] free_slot;
  logic              hit_any;
  logic [SLOT_W-1:0] hit_slot;
  logic [LEN_W-1:0]  hit_n;

  logic              is_seg, is_poll, is_read;
  logic [16:0]       count;
  logic [15:0]       pay_off;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              fp_eff;
  logic [SLOT_W-1:0] fs_eff;
  logic              commit;
  status_e           seg_status;

  assign is_seg  = in_i.operation == OP_SEGMENT;
  assign is_poll = in_i.operation == OP_POLL;
  assign is_read = in_i.operation == OP_READ;

  assign sts_o.imm_result = (is_seg && in_i.last_byte) || is_poll;
  assign sts_o.read_hit   = is_read && (read_rem_q != '0);

  // first free slot, skipping the one being read out
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!free_any && !slot_valid_q[i] &&
          !((read_rem_q != '0) && (read_slot_q == SLOT_W'(i)))) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // first valid slot for the polled port
  always_comb begin
    hit_any  = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!hit_any && slot_valid_q[i] && slot_port_q[i] == in_i.poll_port) begin
        hit_any  = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign hit_n = (16'(slot_len_q[hit_slot]) < in_i.capacity) ? slot_len_q[hit_slot]
                                                             : in_i.capacity[LEN_W-1:0];

  assign count   = {1'b0, bytes_seen_q} + 17'd1;
  assign fp_eff  = (bytes_seen_q == '0) ? free_any : fill_poss_q;
  assign fs_eff  = (bytes_seen_q == '0) ? free_slot : fill_slot_q;
  assign pay_off = bytes_seen_q - 16'(HDR_BYTES);
  assign wr_en   = cmd_i.accept && is_seg && fill_poss_q &&
                   (bytes_seen_q >= 16'(HDR_BYTES)) && (pay_off < 16'(MAX_PAYLOAD));
  assign wr_addr = ADDR_W'(fill_slot_q) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(pay_off);
  assign rd_addr = ADDR_W'(read_slot_q) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(read_idx_q);

  always_comb begin
    commit = 1'b0;
    if (count < 17'(HDR_BYTES)) begin
      seg_status = ST_SHORT_HDR;
    end else if (hdr_len_q < 16'(HDR_BYTES) || {1'b0, hdr_len_q} > count) begin
      seg_status = ST_BAD_LEN;
    end else if (hdr_len_q - 16'(HDR_BYTES) > 16'(MAX_PAYLOAD)) begin
      seg_status = ST_TOO_LONG;
    end else if (!fp_eff) begin
      seg_status = ST_NO_SLOT;
    end else begin
      seg_status = ST_STORED;
      commit     = 1'b1;
    end
  end

  always_comb begin
    imm_out = '0;
    if (is_poll) begin
      imm_out.kind   = KIND_POLL;
      imm_out.found  = hit_any;
      imm_out.length = hit_any ? LENGTH_W'(hit_n) : '0;
    end else begin
      imm_out.kind   = KIND_STATUS;
      imm_out.status = seg_status;
    end
  end

  always_comb begin
    rd_out          = '0;
    rd_out.kind     = KIND_BYTE;
    rd_out.out_byte = rd_data_q;
    rd_out.out_last = rd_last_q;
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    bytes_seen_d = bytes_seen_q;
    hdr_port_d   = hdr_port_q;
    hdr_len_d    = hdr_len_q;
    fill_slot_d  = fill_slot_q;
    fill_poss_d  = fill_poss_q;
    read_slot_d  = read_slot_q;
    read_idx_d   = read_idx_q;
    read_rem_d   = read_rem_q;
    if (cmd_i.accept) begin
      if (is_seg) begin
        if (bytes_seen_q == '0) begin
          fill_slot_d = free_slot;
          fill_poss_d = free_any;
        end
        case (bytes_seen_q)
          16'd2:   hdr_port_d[15:8] = in_i.data_byte;
          16'd3:   hdr_port_d[7:0]  = in_i.data_byte;
          16'd4:   hdr_len_d[15:8]  = in_i.data_byte;
          16'd5:   hdr_len_d[7:0]   = in_i.data_byte;
          default: ;
        endcase
        bytes_seen_d = count[16] ? 16'hFFFF : count[15:0];
        if (in_i.last_byte) begin
          bytes_seen_d = '0;
          fill_poss_d  = 1'b0;
          if (commit) begin
            slot_valid_d[fs_eff] = 1'b1;
          end
        end
      end else if (is_poll) begin
        read_idx_d = '0;
        read_rem_d = '0;
        if (hit_any) begin
          slot_valid_d[hit_slot] = 1'b0;
          read_slot_d            = hit_slot;
          read_rem_d             = hit_n;
        end
      end else if (is_read && read_rem_q != '0) begin
        read_idx_d = read_idx_q + IDX_W'(1);
        read_rem_d = read_rem_q - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      bytes_seen_q <= '0;
      hdr_port_q   <= '0;
      hdr_len_q    <= '0;
      fill_slot_q  <= '0;
      fill_poss_q  <= 1'b0;
      read_slot_q  <= '0;
      read_idx_q   <= '0;
      read_rem_q   <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
      bytes_seen_q <= bytes_seen_d;
      hdr_port_q   <= hdr_port_d;
      hdr_len_q    <= hdr_len_d;
      fill_slot_q  <= fill_slot_d;
      fill_poss_q  <= fill_poss_d;
      read_slot_q  <= read_slot_d;
      read_idx_q   <= read_idx_d;
      read_rem_q   <= read_rem_d;
    end
  end

  // slot descriptors, written on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_seg && in_i.last_byte && commit) begin
      slot_port_q[fs_eff] <= hdr_port_q;
      slot_len_q[fs_eff]  <= LEN_W'(hdr_len_q - 16'(HDR_BYTES));
    end
  end

  // payload memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_i.data_byte;
    end
    if (cmd_i.accept && sts_o.read_hit) begin
      rd_data_q <= mem[rd_addr];
      rd_last_q <= read_rem_q == LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_imm) begin
      out_q <= imm_out;
    end else if (cmd_i.load_rd) begin
      out_q <= rd_out;
    end
  end

  assign out_o = out_q;

  a_reserved_not_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_rem_q != '0 |-> !slot_valid_q[read_slot_q])
    else $error("slot under readout is marked valid");

  a_fill_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_poss_q |-> !slot_valid_q[fill_slot_q])
    else $error("fill slot already holds a datagram");

  a_fill_needs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_seen_q == '0 |-> !fill_poss_q)
    else $error("fill slot held with no segment in progress");

endmodule

// ----- hdl/udp_receive_slot_buffer_top.sv -----
// udp receive slot buffer, top level
// depends on ursb_pkg, ursb_ctrl, ursb_datapath
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+------------------------
//   input    | in_valid_i   | in_stall_o   | in_i  (segment/poll/read)
//   output   | out_valid_o  | out_stall_i  | out_o (status/answer/byte)
//
// segment bytes and polls are taken at one transfer per clock while the input is not stalled
// a read goes through the registered read port of the payload memory and the read state, in which the input stalls
// reset clears slot valid bits and parse state; the payload memory is not cleared
// input stalls while the output register holds a result that is stalled
module udp_receive_slot_buffer_top #(
  parameter int unsigned SLOT_COUNT  = 2,
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ursb_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ursb_pkg::out_t out_o
);
  import ursb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ursb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ursb_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

endmodule
